// ===== src/tsv_pkg.sv =====
`default_nettype none

package tsv_pkg;

	localparam int PIX_W      = 16;
	localparam int COORD_W    = 8;
	localparam int CFG_W      = 9;
	localparam int GRAD_W     = 20;
	localparam int SQ_W       = 32;
	localparam int SUM_W      = 50;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MIN_WIDTH  = 2;
	localparam int MIN_HEIGHT = 1;
	// line store address: row parity on top of the column
	localparam int LINE_AW    = COORD_W + 1;

	// result slots of one pixel, in delivery order
	localparam int RES_TOP  = 0;
	localparam int RES_LEFT = 1;
	localparam int RES_PIX  = 2;
	localparam int RES_N    = 3;

	typedef logic [0:0]              reg_idx_t;
	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic [COORD_W-1:0]      coord_t;
	typedef logic [CFG_W-1:0]        cfg_t;
	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [SQ_W-1:0]         sq_t;
	typedef logic [SUM_W-1:0]        sum_t;

	localparam reg_idx_t REG_WIDTH  = 1'b0;
	localparam reg_idx_t REG_HEIGHT = 1'b1;
	localparam sum_t     SUM_MAX    = '1;

	// one pixel's work, handed from the window stage to the result stage
	typedef struct packed {
		coord_t           row;
		coord_t           col;
		grad_t            g_top;
		grad_t            g_left;
		grad_t            g_pix;
		sq_t              sq_h;
		sq_t              sq_v;
		logic [RES_N-1:0] mask;
		logic             clr_sum;
		logic             last_pix;
	} stage_t;

	// 2 * sum over present neighbors of (x0 - neighbor)
	function automatic grad_t grad4(pix_t x0, logic hl, pix_t l, logic hr, pix_t rr,
			logic hu, pix_t u, logic hd, pix_t d);
		logic signed [GRAD_W-2:0] el;
		logic signed [GRAD_W-2:0] er;
		logic signed [GRAD_W-2:0] eu;
		logic signed [GRAD_W-2:0] ed;
		logic signed [GRAD_W-2:0] acc;
		el = (GRAD_W-1)'(x0) - (GRAD_W-1)'(l);
		er = (GRAD_W-1)'(x0) - (GRAD_W-1)'(rr);
		eu = (GRAD_W-1)'(x0) - (GRAD_W-1)'(u);
		ed = (GRAD_W-1)'(x0) - (GRAD_W-1)'(d);
		acc = (hl ? el : '0) + (hr ? er : '0) + (hu ? eu : '0) + (hd ? ed : '0);
		return {acc, 1'b0};
	endfunction

	function automatic sq_t square_diff(pix_t a, pix_t b);
		logic signed [PIX_W:0]     d;
		logic signed [2*PIX_W+1:0] p;
		d = (PIX_W+1)'(a) - (PIX_W+1)'(b);
		p = d * d;
		return p[SQ_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/tsv_cell.sv =====
`default_nettype none

module tsv_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          seed_en,
	input  tsv_pkg::pix_t seed,
	input  tsv_pkg::pix_t mid_in,
	input  tsv_pkg::pix_t cur_in,
	output tsv_pkg::pix_t mid_out,
	output tsv_pkg::pix_t cur_out
);
	import tsv_pkg::*;

	// one window column: row above and current row
	pix_t mid_q;
	pix_t cur_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			mid_q <= mid_in;
			cur_q <= cur_in;
		end
	end

	// at a row start the row above comes from the seed, not from the chain
	assign mid_out = seed_en ? seed : mid_q;
	assign cur_out = cur_q;

endmodule

`default_nettype wire

// ===== src/tsv_emit.sv =====
`default_nettype none

module tsv_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            stage_valid,
	input  tsv_pkg::stage_t stage_in,
	output logic            stage_take,
	output logic            grad_valid,
	input  logic            grad_stall,
	output tsv_pkg::coord_t grad_col,
	output tsv_pkg::coord_t grad_row,
	output tsv_pkg::grad_t  gradient,
	output tsv_pkg::sum_t   variation_sum,
	output logic            last
);
	import tsv_pkg::*;

	logic             s2_v_q;
	stage_t           s2_q;
	logic [RES_N-1:0] pend_q;
	logic [RES_N-1:0] pick;
	logic [RES_N-1:0] rem;
	sum_t             sum_q;
	sum_t             base;
	logic [SUM_W:0]   total;
	sum_t             sum_sat;
	logic             out_free;
	logic             emit_now;
	logic             s2_done;

	logic             grad_valid_q;
	coord_t           grad_col_q;
	coord_t           grad_row_q;
	grad_t            gradient_q;
	sum_t             variation_sum_q;
	logic             last_q;
	coord_t           nxt_col;
	coord_t           nxt_row;
	grad_t            nxt_grad;
	sum_t             nxt_vsum;
	logic             nxt_last;

	always_comb begin
		pick = '0;
		if (pend_q[RES_TOP]) begin
			pick[RES_TOP] = 1'b1;
		end else if (pend_q[RES_LEFT]) begin
			pick[RES_LEFT] = 1'b1;
		end else if (pend_q[RES_PIX]) begin
			pick[RES_PIX] = 1'b1;
		end
	end

	assign rem      = pend_q & ~pick;
	assign out_free = !grad_valid_q || !grad_stall;
	assign emit_now = s2_v_q && (pend_q != '0) && out_free;
	// an item with no results retires at once
	assign s2_done  = s2_v_q && ((pend_q == '0) || (emit_now && (rem == '0)));
	assign stage_take = !s2_v_q || s2_done;

	assign base    = s2_q.clr_sum ? '0 : sum_q;
	assign total   = {1'b0, base} + (SUM_W+1)'(s2_q.sq_h) + (SUM_W+1)'(s2_q.sq_v);
	assign sum_sat = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];

	always_comb begin
		nxt_col  = s2_q.col;
		nxt_row  = s2_q.row;
		nxt_grad = s2_q.g_pix;
		nxt_vsum = '0;
		nxt_last = 1'b0;
		if (pick[RES_TOP]) begin
			nxt_row  = s2_q.row - 1'b1;
			nxt_grad = s2_q.g_top;
		end else if (pick[RES_LEFT]) begin
			nxt_col  = s2_q.col - 1'b1;
			nxt_grad = s2_q.g_left;
		end else begin
			nxt_vsum = sum_sat;
			nxt_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q       <= 1'b0;
			pend_q       <= '0;
			sum_q        <= '0;
			grad_valid_q <= 1'b0;
		end else begin
			if (stage_valid && stage_take) begin
				s2_v_q <= 1'b1;
				pend_q <= stage_in.mask;
			end else if (s2_done) begin
				s2_v_q <= 1'b0;
				pend_q <= '0;
			end else if (emit_now) begin
				pend_q <= rem;
			end
			// fold this pixel's squares in as it retires; drop the sum after the last pixel
			if (s2_done) begin
				sum_q <= s2_q.last_pix ? '0 : sum_sat;
			end
			if (emit_now) begin
				grad_valid_q <= 1'b1;
			end else if (!grad_stall) begin
				grad_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_valid && stage_take) begin
			s2_q <= stage_in;
		end
		if (emit_now) begin
			grad_col_q      <= nxt_col;
			grad_row_q      <= nxt_row;
			gradient_q      <= nxt_grad;
			variation_sum_q <= nxt_vsum;
			last_q          <= nxt_last;
		end
	end

	assign grad_valid    = grad_valid_q;
	assign grad_col      = grad_col_q;
	assign grad_row      = grad_row_q;
	assign gradient      = gradient_q;
	assign variation_sum = variation_sum_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// ===== src/total_squared_variation_2d_unit.sv =====
`default_nettype none

// channel   direction  handshake               payload
// pixel     in         pixel_valid/pixel_stall pixel
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
// grad      out        grad_valid/grad_stall   grad_col, grad_row, gradient,
//                                              variation_sum, last
//
// One pixel per cycle while the result side keeps up; in the last row a pixel past column zero
// releases two results (one in a single-row image) and the final pixel up to three, which the
// single result port sends one at a time. A result passes the line store read, the window stage
// and the output register, in that order, after the edge that takes its pixel.
// The line store is not cleared by reset; every read it serves was written in the image.
// A stalled result register holds and the pixel channel stalls once the window stage fills.
module total_squared_variation_2d_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  tsv_pkg::pix_t     pixel,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  tsv_pkg::reg_idx_t cfg_index,
	input  tsv_pkg::cfg_t     cfg_data,
	output logic              grad_valid,
	input  logic              grad_stall,
	output tsv_pkg::coord_t   grad_col,
	output tsv_pkg::coord_t   grad_row,
	output tsv_pkg::grad_t    gradient,
	output tsv_pkg::sum_t     variation_sum,
	output logic              last
);
	import tsv_pkg::*;

	typedef struct packed {
		coord_t row;
		coord_t col;
		logic   c_gt0;
		logic   c_gt1;
		logic   c_inner;
		logic   r_gt0;
		logic   r_gt1;
		logic   last_row;
		logic   last_pix;
		logic   clr_sum;
	} pos_t;

	cfg_t   width_q;
	cfg_t   height_q;
	cfg_t   w_eff;
	cfg_t   h_eff;
	coord_t col_q;
	coord_t row_q;
	logic   col_wrap;
	logic   h_wrap;
	cfg_t   row_pre;
	coord_t r0;
	coord_t c0;
	cfg_t   col_nxt;
	cfg_t   row_nxt;
	logic   last_row;
	logic   last_pix;
	pos_t   pos_s0;

	logic   accept;
	logic   s1_v_q;
	logic   s1_adv;
	logic   stage_take;
	pos_t   pos_s1;
	pix_t   x_s1;
	pix_t   up_s1;
	pix_t   right_s1;
	pix_t   row_head_q;
	pix_t   line_mem [2*MAX_WIDTH];
	logic [LINE_AW-1:0] addr_a;
	logic [LINE_AW-1:0] addr_b;

	pix_t   mid_c;
	pix_t   mid_l;
	pix_t   cur_l;
	pix_t   cur_ll;
	stage_t stage_d;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(MAX_WIDTH);
			height_q <= CFG_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q < CFG_W'(MIN_WIDTH)) ? CFG_W'(MIN_WIDTH) :
		(width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q < CFG_W'(MIN_HEIGHT)) ? CFG_W'(MIN_HEIGHT) :
		(height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;

	// position of the arriving pixel
	assign col_wrap = {1'b0, col_q} >= w_eff;
	assign row_pre  = col_wrap ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
	assign h_wrap   = row_pre >= h_eff;
	assign r0       = h_wrap ? '0 : row_pre[COORD_W-1:0];
	assign c0       = col_wrap ? '0 : col_q;
	assign last_row = {1'b0, r0} == (h_eff - 1'b1);
	assign last_pix = last_row && ({1'b0, c0} == (w_eff - 1'b1));
	assign col_nxt  = {1'b0, c0} + 1'b1;
	assign row_nxt  = {1'b0, r0} + 1'b1;

	always_comb begin
		pos_s0.row      = r0;
		pos_s0.col      = c0;
		pos_s0.c_gt0    = c0 != '0;
		pos_s0.c_gt1    = c0 > COORD_W'(1);
		pos_s0.c_inner  = {1'b0, c0} < (w_eff - 1'b1);
		pos_s0.r_gt0    = r0 != '0;
		pos_s0.r_gt1    = r0 > COORD_W'(1);
		pos_s0.last_row = last_row;
		pos_s0.last_pix = last_pix;
		pos_s0.clr_sum  = h_wrap;
	end

	assign pixel_stall = s1_v_q && !stage_take;
	assign accept      = pixel_valid && !pixel_stall;
	assign s1_adv      = s1_v_q && stage_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_pix) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_nxt >= w_eff) begin
					col_q <= '0;
					row_q <= row_nxt[COORD_W-1:0];
				end else begin
					col_q <= col_nxt[COORD_W-1:0];
					row_q <= r0;
				end
			end
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	// line store: up = two rows back at this column, right = row above one column on
	assign addr_b = {r0[0], c0};
	assign addr_a = {~r0[0], col_nxt[COORD_W-1:0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1            <= line_mem[addr_b];
			right_s1         <= line_mem[addr_a];
			line_mem[addr_b] <= pixel;
			pos_s1           <= pos_s0;
			x_s1             <= pixel;
		end
	end

	// first pixel of each row seeds the window at the next row start
	always_ff @(posedge clk) begin
		if (s1_adv && !pos_s1.c_gt0) begin
			row_head_q <= x_s1;
		end
	end

	tsv_cell u_cell0 (
		.clk     (clk),
		.shift   (s1_adv),
		.seed_en (!pos_s1.c_gt0),
		.seed    (row_head_q),
		.mid_in  (right_s1),
		.cur_in  (x_s1),
		.mid_out (mid_c),
		.cur_out (cur_l)
	);

	tsv_cell u_cell1 (
		.clk     (clk),
		.shift   (s1_adv),
		.seed_en (1'b0),
		.seed    ('0),
		.mid_in  (mid_c),
		.cur_in  (cur_l),
		.mid_out (mid_l),
		.cur_out (cur_ll)
	);

	always_comb begin
		stage_d.row      = pos_s1.row;
		stage_d.col      = pos_s1.col;
		stage_d.g_top    = grad4(mid_c, pos_s1.c_gt0, mid_l, pos_s1.c_inner, right_s1,
			pos_s1.r_gt1, up_s1, 1'b1, x_s1);
		stage_d.g_left   = grad4(cur_l, pos_s1.c_gt1, cur_ll, 1'b1, x_s1,
			pos_s1.r_gt0, mid_l, 1'b0, x_s1);
		stage_d.g_pix    = grad4(x_s1, 1'b1, cur_l, 1'b0, x_s1,
			pos_s1.r_gt0, mid_c, 1'b0, x_s1);
		stage_d.sq_h     = pos_s1.c_gt0 ? square_diff(cur_l, x_s1) : '0;
		stage_d.sq_v     = pos_s1.r_gt0 ? square_diff(mid_c, x_s1) : '0;
		stage_d.mask[RES_TOP]  = pos_s1.r_gt0;
		stage_d.mask[RES_LEFT] = pos_s1.last_row && pos_s1.c_gt0;
		stage_d.mask[RES_PIX]  = pos_s1.last_pix;
		stage_d.clr_sum  = pos_s1.clr_sum;
		stage_d.last_pix = pos_s1.last_pix;
	end

	tsv_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.stage_valid   (s1_v_q),
		.stage_in      (stage_d),
		.stage_take    (stage_take),
		.grad_valid    (grad_valid),
		.grad_stall    (grad_stall),
		.grad_col      (grad_col),
		.grad_row      (grad_row),
		.gradient      (gradient),
		.variation_sum (variation_sum),
		.last          (last)
	);

endmodule

`default_nettype wire

// ===== src/tsv_checker.sv =====
`default_nettype none

module tsv_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            grad_valid,
	input logic            grad_stall,
	input tsv_pkg::coord_t grad_col,
	input tsv_pkg::coord_t grad_row,
	input tsv_pkg::grad_t  gradient,
	input tsv_pkg::sum_t   variation_sum,
	input logic            last
);

	// set while the next result opens an image
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (grad_valid && !grad_stall) begin
			first_q <= last;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && grad_stall |=> grad_valid)
		else $error("result transaction dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && grad_stall |=> $stable(gradient) && $stable(grad_row) &&
			$stable(grad_col) && $stable(last))
		else $error("stalled result transaction changed");

	a_sum_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && !last |-> variation_sum == '0)
		else $error("variation sum on a result that is not last");

	a_image_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && first_q |-> grad_row == '0)
		else $error("first result of an image not from row zero");

endmodule

bind total_squared_variation_2d_unit tsv_checker u_tsv_checker (.*);

`default_nettype wire

// ===== tb/sv/tsv_gradient_checker.sv =====
`timescale 1ns / 1ps

module tsv_gradient_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	input  logic              pixel_stall,
	input  tsv_pkg::pix_t     pixel,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  tsv_pkg::reg_idx_t cfg_index,
	input  tsv_pkg::cfg_t     cfg_data,
	input  logic              grad_valid,
	input  logic              grad_stall,
	input  tsv_pkg::coord_t   grad_col,
	input  tsv_pkg::coord_t   grad_row,
	input  tsv_pkg::grad_t    gradient,
	input  tsv_pkg::sum_t     variation_sum,
	input  logic              last,
	output int                fail_count,
	output int                pending
);
	import tsv_pkg::*;

	localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		coord_t col;
		coord_t row;
		grad_t  grad;
		sum_t   vsum;
		logic   last;
	} grad_res_t;

	// predicted block state
	pix_t            line_buf [2][MAX_WIDTH];
	int unsigned     col_cnt;
	int unsigned     row_cnt;
	longint unsigned tv_sum;
	int              prev_pix;
	cfg_t            width_reg;
	cfg_t            height_reg;

	grad_res_t pending_grads [$];
	int        mismatch_cnt;

	function automatic int line_px(int unsigned par, int unsigned c);
		if (c >= MAX_WIDTH)
			return 0;
		return line_buf[par & 1][c];
	endfunction

	function automatic void accumulate_sq(int a, int b);
		longint d;
		d = longint'(a) - longint'(b);
		tv_sum += longint'(d * d);
		if (tv_sum > SUM_LIMIT)
			tv_sum = SUM_LIMIT;
	endfunction

	function automatic grad_t tv_grad(int x0, bit hl, int l, bit hr, int rt, bit hu, int u,
			bit hd, int dn);
		int acc;
		acc = 0;
		if (hl) acc += x0 - l;
		if (hr) acc += x0 - rt;
		if (hu) acc += x0 - u;
		if (hd) acc += x0 - dn;
		return grad_t'(2 * acc);
	endfunction

	function automatic void queue_grad(int unsigned r, int unsigned c, grad_t g,
			longint unsigned s, bit lst);
		grad_res_t e;
		e.col  = coord_t'(c);
		e.row  = coord_t'(r);
		e.grad = g;
		e.vsum = sum_t'(s);
		e.last = lst;
		pending_grads.push_back(e);
	endfunction

	// gradients that one accepted pixel releases, in delivery order
	task automatic compute_gradients(input pix_t px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned cur;
		int unsigned oth;
		int          x;
		bit          last_row;
		bit          last_pix;
		w = width_reg;
		h = height_reg;
		if (w < MIN_WIDTH) w = MIN_WIDTH;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < MIN_HEIGHT) h = MIN_HEIGHT;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		// a register change may have left the position outside the image
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h) begin
			row_cnt = 0;
			tv_sum = 0;
		end

		r = row_cnt;
		c = col_cnt;
		x = px;
		cur = r & 1;
		oth = cur ^ 1;
		last_row = (r == h - 1);
		last_pix = last_row && (c == w - 1);

		if (c > 0) accumulate_sq(prev_pix, x);
		if (r > 0) accumulate_sq(line_px(oth, c), x);

		// the pixel above is complete now; row r-2 still sits in this parity
		if (r > 0)
			queue_grad(r - 1, c, tv_grad(line_px(oth, c),
				c > 0, (c > 0) ? line_px(oth, c - 1) : 0,
				c < w - 1, line_px(oth, c + 1),
				r > 1, line_px(cur, c),
				1'b1, x), 0, 1'b0);

		line_buf[cur][c] = px;

		if (last_row && c > 0)
			queue_grad(r, c - 1, tv_grad(line_px(cur, c - 1),
				c > 1, (c > 1) ? line_px(cur, c - 2) : 0,
				1'b1, x,
				r > 0, line_px(oth, c - 1),
				1'b0, 0), 0, 1'b0);

		if (last_pix)
			queue_grad(r, c, tv_grad(x,
				1'b1, line_px(cur, c - 1),
				1'b0, 0,
				r > 0, line_px(oth, c),
				1'b0, 0), tv_sum, 1'b1);

		prev_pix = x;
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
		end
		if (last_pix) begin
			col_cnt = 0;
			row_cnt = 0;
			tv_sum = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grad_res_t want;
		grad_res_t got;
		if (!arst_n) begin
			for (int p = 0; p < 2; p++)
				for (int i = 0; i < MAX_WIDTH; i++)
					line_buf[p][i] = '0;
			col_cnt = 0;
			row_cnt = 0;
			tv_sum = 0;
			prev_pix = 0;
			width_reg = cfg_t'(MAX_WIDTH);
			height_reg = cfg_t'(MAX_HEIGHT);
			pending_grads.delete();
			mismatch_cnt = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (grad_valid && !grad_stall) begin
				got.col  = grad_col;
				got.row  = grad_row;
				got.grad = gradient;
				got.vsum = variation_sum;
				got.last = last;
				if (pending_grads.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_LIMIT)
						$display("%0t: unexpected gradient col %0d row %0d grad %0d sum %0d last %0b",
							$time, got.col, got.row, got.grad, got.vsum, got.last);
				end else begin
					want = pending_grads.pop_front();
					if (got.col !== want.col || got.row !== want.row || got.grad !== want.grad
							|| got.vsum !== want.vsum || got.last !== want.last) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_LIMIT)
							$display("%0t: gradient mismatch exp col %0d row %0d grad %0d sum %0d last %0b / got col %0d row %0d grad %0d sum %0d last %0b",
								$time, want.col, want.row, want.grad, want.vsum, want.last,
								got.col, got.row, got.grad, got.vsum, got.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (pixel_valid && !pixel_stall)
				compute_gradients(pixel);
			fail_count <= mismatch_cnt;
			pending <= pending_grads.size();
		end
	end

endmodule

// ===== tb/sv/total_squared_variation_2d_unit_tb.sv =====
`timescale 1ns / 1ps

module total_squared_variation_2d_unit_tb;
	import tsv_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int RANDOM_ITEMS   = 30;
	localparam int IDLE_PCT       = 35;
	localparam pix_t PIX_MAX = 16'sh7FFF;
	localparam pix_t PIX_MIN = 16'sh8000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    pixel_valid = 1'b0;
	logic    pixel_stall;
	pix_t    pixel = '0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	reg_idx_t cfg_index = REG_WIDTH;
	cfg_t    cfg_data = '0;
	logic    grad_valid;
	logic    grad_stall = 1'b0;
	coord_t  grad_col;
	coord_t  grad_row;
	grad_t   gradient;
	sum_t    variation_sum;
	logic    last;

	int mismatches;
	int results_pending;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	total_squared_variation_2d_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.grad_valid(grad_valid),
		.grad_stall(grad_stall),
		.grad_col(grad_col),
		.grad_row(grad_row),
		.gradient(gradient),
		.variation_sum(variation_sum),
		.last(last)
	);

	tsv_gradient_checker grad_chk (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.grad_valid(grad_valid),
		.grad_stall(grad_stall),
		.grad_col(grad_col),
		.grad_row(grad_row),
		.gradient(gradient),
		.variation_sum(variation_sum),
		.last(last),
		.fail_count(mismatches),
		.pending(results_pending)
	);

	initial begin
		forever begin
			#2 clk = ~clk;
		end
	end

	function automatic pix_t rand_pixel();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return pix_t'($urandom);
		if (sel < 80)
			return pix_t'(int'($urandom_range(16)) - 8);
		case ($urandom_range(3))
			0: return PIX_MAX;
			1: return PIX_MIN;
			2: return pix_t'(0);
			default: return pix_t'(-1);
		endcase
	endfunction

	// leaves valid high; the next transaction or the drain decides what follows
	task automatic send_pixel(input pix_t v);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= v;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	// hold off until every predicted gradient is out, then let the pipe settle
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input cfg_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input cfg_t w, input cfg_t h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// result side: random stalls, one long hold-off on request, quiet while calm
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				grad_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				grad_stall <= 1'b0;
			end else begin
				grad_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pixel_valid && !pixel_stall) || (grad_valid && !grad_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int rand_items;
		int w;
		int h;
		int n;
		rand_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// full-scale checkerboards, then the inverse, on a 3x3 image
		configure(cfg_t'(3), cfg_t'(3));
		for (int i = 0; i < 18; i++)
			send_pixel((((i % 9) + i / 9) % 2) ? PIX_MIN : PIX_MAX);
		wait_drained();

		// zero registers clamp to a 2x1 image
		configure(cfg_t'(0), cfg_t'(0));
		send_pixel(pix_t'(0));
		send_pixel(pix_t'(-1));
		send_pixel(pix_t'(1));
		send_pixel(PIX_MAX);
		wait_drained();

		// oversized width register clamps: the row runs on past column one
		configure(cfg_t'(300), cfg_t'(1));
		send_random(2);
		wait_drained();
		// narrower width ends the row, and with one row a new image begins
		write_reg(REG_WIDTH, cfg_t'(2));
		send_random(2);
		wait_drained();

		// steady stream with no idling; stall the result side meanwhile
		configure(cfg_t'(12), cfg_t'(6));
		calm = 1'b1;
		hold_req = 1'b1;
		send_random(72);
		wait_drained();
		calm = 1'b0;

		// tallest image, cut short by a smaller height: a new image begins
		configure(cfg_t'(2), cfg_t'(256));
		send_random(10);
		wait_drained();
		write_reg(REG_HEIGHT, cfg_t'(3));
		send_random(6);
		wait_drained();

		// narrower width mid-row: jump to the next row
		configure(cfg_t'(8), cfg_t'(4));
		send_random(13);
		wait_drained();
		write_reg(REG_WIDTH, cfg_t'(4));
		send_random(8);
		wait_drained();

		// lower height mid-row turns the current row into the last one
		configure(cfg_t'(5), cfg_t'(6));
		send_random(12);
		wait_drained();
		write_reg(REG_HEIGHT, cfg_t'(3));
		send_random(3);
		wait_drained();

		configure(cfg_t'(3), cfg_t'(400));
		send_random(9);
		wait_drained();
		write_reg(REG_HEIGHT, cfg_t'(2));
		send_random(6);
		wait_drained();

		configure(cfg_t'(1), cfg_t'(511));
		send_random(6);
		wait_drained();
		write_reg(REG_HEIGHT, cfg_t'(1));
		send_random(2);
		wait_drained();

		while (rand_items < RANDOM_ITEMS) begin
			w = $urandom_range(8, 2);
			h = $urandom_range(4, 1);
			n = w * h * $urandom_range(2, 1);
			configure(cfg_t'(w), cfg_t'(h));
			send_random(n);
			rand_items += n;
			wait_drained();
		end

		if (mismatches == 0 && results_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
